// ----- src/ps2asc_pkg.sv -----
// Package for the set-1 scan code to ASCII decoder with character FIFO.
// Holds shared constants, the control FSM states, FIFO control structs and key maps.
// No dependencies.
`default_nettype none

package ps2asc_pkg;

    localparam int DEPTH_DEF = 128;

    localparam logic [7:0] BREAK_BIT   = 8'h80;
    localparam logic [6:0] CODE_MASK   = 7'h7F;
    localparam logic [6:0] LSHIFT_CODE = 7'h2A;
    localparam logic [6:0] RSHIFT_CODE = 7'h36;
    localparam logic [7:0] TABLE_LEN   = 8'd59;

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } ctrl_state_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

    function automatic logic [6:0] plain_map(input logic [5:0] code);
        logic [6:0] ch;
        case (code)
            6'd1:    ch = 7'h1B;
            6'd2:    ch = 7'h31;
            6'd3:    ch = 7'h32;
            6'd4:    ch = 7'h33;
            6'd5:    ch = 7'h34;
            6'd6:    ch = 7'h35;
            6'd7:    ch = 7'h36;
            6'd8:    ch = 7'h37;
            6'd9:    ch = 7'h38;
            6'd10:   ch = 7'h39;
            6'd11:   ch = 7'h30;
            6'd12:   ch = 7'h2D;
            6'd13:   ch = 7'h3D;
            6'd14:   ch = 7'h08;
            6'd15:   ch = 7'h09;
            6'd16:   ch = 7'h71;
            6'd17:   ch = 7'h77;
            6'd18:   ch = 7'h65;
            6'd19:   ch = 7'h72;
            6'd20:   ch = 7'h74;
            6'd21:   ch = 7'h79;
            6'd22:   ch = 7'h75;
            6'd23:   ch = 7'h69;
            6'd24:   ch = 7'h6F;
            6'd25:   ch = 7'h70;
            6'd26:   ch = 7'h5B;
            6'd27:   ch = 7'h5D;
            6'd28:   ch = 7'h0A;
            6'd30:   ch = 7'h61;
            6'd31:   ch = 7'h73;
            6'd32:   ch = 7'h64;
            6'd33:   ch = 7'h66;
            6'd34:   ch = 7'h67;
            6'd35:   ch = 7'h68;
            6'd36:   ch = 7'h6A;
            6'd37:   ch = 7'h6B;
            6'd38:   ch = 7'h6C;
            6'd39:   ch = 7'h3B;
            6'd40:   ch = 7'h27;
            6'd41:   ch = 7'h60;
            6'd43:   ch = 7'h5C;
            6'd44:   ch = 7'h7A;
            6'd45:   ch = 7'h78;
            6'd46:   ch = 7'h63;
            6'd47:   ch = 7'h76;
            6'd48:   ch = 7'h62;
            6'd49:   ch = 7'h6E;
            6'd50:   ch = 7'h6D;
            6'd51:   ch = 7'h2C;
            6'd52:   ch = 7'h2E;
            6'd53:   ch = 7'h2F;
            6'd55:   ch = 7'h2A;
            6'd57:   ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [6:0] upper_map(input logic [5:0] code);
        logic [6:0] ch;
        case (code)
            6'd1:    ch = 7'h1B;
            6'd2:    ch = 7'h21;
            6'd3:    ch = 7'h40;
            6'd4:    ch = 7'h23;
            6'd5:    ch = 7'h24;
            6'd6:    ch = 7'h25;
            6'd7:    ch = 7'h5E;
            6'd8:    ch = 7'h26;
            6'd9:    ch = 7'h2A;
            6'd10:   ch = 7'h28;
            6'd11:   ch = 7'h29;
            6'd12:   ch = 7'h5F;
            6'd13:   ch = 7'h2B;
            6'd14:   ch = 7'h08;
            6'd15:   ch = 7'h09;
            6'd16:   ch = 7'h51;
            6'd17:   ch = 7'h57;
            6'd18:   ch = 7'h45;
            6'd19:   ch = 7'h52;
            6'd20:   ch = 7'h54;
            6'd21:   ch = 7'h59;
            6'd22:   ch = 7'h55;
            6'd23:   ch = 7'h49;
            6'd24:   ch = 7'h4F;
            6'd25:   ch = 7'h50;
            6'd26:   ch = 7'h7B;
            6'd27:   ch = 7'h7D;
            6'd28:   ch = 7'h0A;
            6'd30:   ch = 7'h41;
            6'd31:   ch = 7'h53;
            6'd32:   ch = 7'h44;
            6'd33:   ch = 7'h46;
            6'd34:   ch = 7'h47;
            6'd35:   ch = 7'h48;
            6'd36:   ch = 7'h4A;
            6'd37:   ch = 7'h4B;
            6'd38:   ch = 7'h4C;
            6'd39:   ch = 7'h3A;
            6'd40:   ch = 7'h22;
            6'd41:   ch = 7'h7E;
            6'd43:   ch = 7'h7C;
            6'd44:   ch = 7'h5A;
            6'd45:   ch = 7'h58;
            6'd46:   ch = 7'h43;
            6'd47:   ch = 7'h56;
            6'd48:   ch = 7'h42;
            6'd49:   ch = 7'h4E;
            6'd50:   ch = 7'h4D;
            6'd51:   ch = 7'h3C;
            6'd52:   ch = 7'h3E;
            6'd53:   ch = 7'h3F;
            6'd55:   ch = 7'h2A;
            6'd57:   ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- src/ps2asc_if.sv -----
// Channel interfaces for the scan code decoder: command in, character result out.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface ps2asc_req_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] scan_code;

    modport source (output valid, output cmd, output scan_code, input ready);
    modport sink   (input valid, input cmd, input scan_code, output ready);
endinterface

interface ps2asc_rsp_if;
    logic       valid;
    logic       ready;
    logic       char_valid;
    logic [6:0] ascii_char;
    logic       dropped;

    modport source (output valid, output char_valid, output ascii_char, output dropped,
                    input ready);
    modport sink   (input valid, input char_valid, input ascii_char, input dropped,
                    output ready);
endinterface

`default_nettype wire

// ----- src/ps2asc_decode.sv -----
// Scan code decoder: tracks the shift keys and maps make codes to ASCII.
// Depends on ps2asc_pkg for key codes and the key maps.
`default_nettype none

module ps2asc_decode
    import ps2asc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       scan_en,
    input  wire logic [7:0] scan_code,
    output logic [6:0]      ascii_char
);

    logic       shift_reg;
    logic       shift_next;
    logic [6:0] key;
    logic       is_break;
    logic       is_shift;

    assign key      = scan_code[6:0] & CODE_MASK;
    assign is_break = |(scan_code & BREAK_BIT);
    assign is_shift = (key == LSHIFT_CODE) || (key == RSHIFT_CODE);

    always_comb
    begin
        shift_next = shift_reg;
        if (scan_en && is_shift)
        begin
            shift_next = !is_break;
        end
    end

    always_comb
    begin
        ascii_char = 7'h00;
        if (!is_break && !is_shift && (scan_code < TABLE_LEN))
        begin
            ascii_char = shift_reg ? upper_map(scan_code[5:0]) : plain_map(scan_code[5:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
        end
        else
        begin
            shift_reg <= shift_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/ps2asc_fifo.sv -----
// Character ring buffer: synchronous memory with registered read data and two pointers.
// Depends on ps2asc_pkg for the control and status structs.
`default_nettype none

module ps2asc_fifo
    import ps2asc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire fifo_ctrl_t   ctrl,
    input  wire logic [6:0]   wdata,
    output fifo_status_t      status,
    output logic [6:0]        rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [6:0]       mem [DEPTH];
    logic [6:0]       rdata_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_inc;

    assign wr_ptr_inc = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_inc = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);

    assign status.empty = (wr_ptr_reg == rd_ptr_reg);
    assign status.full  = (wr_ptr_inc == rd_ptr_reg);
    assign rdata        = rdata_reg;

    always_comb
    begin
        wr_ptr_next = ctrl.push ? wr_ptr_inc : wr_ptr_reg;
        rd_ptr_next = ctrl.pop  ? rd_ptr_inc : rd_ptr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
        if (ctrl.pop)
        begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |-> !status.full)
        else $error("push into full buffer");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> !status.empty)
        else $error("pop from empty buffer");

    a_pop_leaves_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |=> !status.full)
        else $error("buffer full straight after a pop");

endmodule

`default_nettype wire

// ----- src/ps2asc_top_ctrl_note.sv -----
// Result register and transaction control for the decoder and ring buffer.
// Depends on ps2asc_pkg for the control FSM states and FIFO structs.
`default_nettype none

module ps2asc_ctrl
    import ps2asc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    input  wire logic         req_cmd,
    output logic              req_ready,
    input  wire logic [6:0]   dec_char,
    output logic              scan_en,
    input  wire fifo_status_t status,
    input  wire logic [6:0]   rdata,
    output fifo_ctrl_t        ctrl,
    output logic              rsp_valid,
    input  wire logic         rsp_ready,
    output logic              rsp_char_valid,
    output logic [6:0]        rsp_ascii_char,
    output logic              rsp_dropped
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic       char_valid_reg;
    logic       char_valid_next;
    logic [6:0] char_reg;
    logic [6:0] char_next;
    logic       dropped_reg;
    logic       dropped_next;

    logic slot_free;
    logic accept;
    logic load;

    assign slot_free = !out_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_cmd == CMD_POP) && !status.empty)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready       = 1'b0;
        scan_en         = 1'b0;
        ctrl            = '0;
        load            = 1'b0;
        char_valid_next = char_valid_reg;
        char_next       = char_reg;
        dropped_next    = dropped_reg;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = slot_free;
                if (accept)
                begin
                    if (req_cmd == CMD_SCAN)
                    begin
                        scan_en         = 1'b1;
                        load            = 1'b1;
                        char_valid_next = (dec_char != 7'h00);
                        char_next       = dec_char;
                        dropped_next    = (dec_char != 7'h00) && status.full;
                        ctrl.push       = (dec_char != 7'h00) && !status.full;
                    end
                    else if (status.empty)
                    begin
                        load            = 1'b1;
                        char_valid_next = 1'b0;
                        char_next       = 7'h00;
                        dropped_next    = 1'b0;
                    end
                    else
                    begin
                        ctrl.pop = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    load            = 1'b1;
                    char_valid_next = 1'b1;
                    char_next       = rdata;
                    dropped_next    = 1'b0;
                end
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
        out_valid_next = load || (out_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_valid_reg <= char_valid_next;
        char_reg       <= char_next;
        dropped_reg    <= dropped_next;
    end

    assign rsp_valid      = out_valid_reg;
    assign rsp_char_valid = char_valid_reg;
    assign rsp_ascii_char = char_reg;
    assign rsp_dropped    = dropped_reg;

    a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |=> (state_reg == ST_READ))
        else $error("pop issued without a read cycle");

    a_drop_has_char: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && dropped_reg) |-> (char_valid_reg && (char_reg != 7'h00)))
        else $error("dropped flagged without a character");

    a_read_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_cmd == CMD_POP) && !status.empty) |=> !req_ready)
        else $error("new transaction taken during buffer read");

endmodule

`default_nettype wire

// ----- src/ps2_scancode_ascii_fifo.sv -----
// Scan code set 1 to ASCII decoder with a character ring buffer: a scan transaction
// echoes the decoded character at once and stores it if there is room; a pop
// transaction returns the oldest stored character. A scan or a pop of an empty
// buffer loads the result register directly; a pop that returns a character
// first waits in ST_READ for the registered read data of the buffer memory.
// The buffer holds DEPTH-1 characters and needs no clearing after reset.
// Depends on ps2asc_pkg, ps2asc_if, ps2asc_decode, ps2asc_fifo and ps2asc_ctrl.
`default_nettype none

module ps2_scancode_ascii_fifo
    import ps2asc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    ps2asc_req_if.sink    req,
    ps2asc_rsp_if.source  rsp
);

    logic         scan_en;
    logic [6:0]   dec_char;
    logic [6:0]   rdata;
    fifo_ctrl_t   ctrl;
    fifo_status_t status;

    ps2asc_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_en    (scan_en),
        .scan_code  (req.scan_code),
        .ascii_char (dec_char)
    );

    ps2asc_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .wdata  (dec_char),
        .status (status),
        .rdata  (rdata)
    );

    ps2asc_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req.valid),
        .req_cmd        (req.cmd),
        .req_ready      (req.ready),
        .dec_char       (dec_char),
        .scan_en        (scan_en),
        .status         (status),
        .rdata          (rdata),
        .ctrl           (ctrl),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .rsp_char_valid (rsp.char_valid),
        .rsp_ascii_char (rsp.ascii_char),
        .rsp_dropped    (rsp.dropped)
    );

endmodule

`default_nettype wire
